// ===== hw/rtl/sqvt_pkg.sv =====
// Shared types, constants and helper functions for the sprite quad vertex transform.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sqvt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int CW = 34;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic signed [20:0] ANG_PI = 21'sd205887;
  localparam logic signed [20:0] ANG_TWO_PI = 21'sd411775;
  localparam logic signed [20:0] ANG_HALF_PI = 21'sd102944;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'h26DD3B6A);

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef logic signed [31:0] q16_t;

  typedef enum logic [3:0] {
    REG_CORNER_LEFT   = 4'd0,
    REG_CORNER_TOP    = 4'd1,
    REG_CORNER_RIGHT  = 4'd2,
    REG_CORNER_BOTTOM = 4'd3,
    REG_UV_CORNERS    = 4'd4,
    REG_DEPTH         = 4'd5,
    REG_COLORS_FIRST  = 4'd6,
    REG_COLORS_SECOND = 4'd7
  } sqvt_reg_t;

  typedef struct packed {
    q16_t        corner_left;
    q16_t        corner_top;
    q16_t        corner_right;
    q16_t        corner_bottom;
    logic [63:0] uv_corners;
    logic [15:0] depth;
    logic [63:0] colors_first_pair;
    logic [63:0] colors_second_pair;
  } sqvt_cfg_t;

  typedef struct packed {
    q16_t px;
    q16_t py;
    q16_t l;
    q16_t r;
    q16_t t;
    q16_t b;
    logic rot;
  } sqvt_carry_t;

  typedef struct packed {
    sqvt_carry_t          geo;
    logic signed [CW-1:0] sin_v;
    logic signed [CW-1:0] cos_v;
  } sqvt_item_t;

  function automatic q16_t sat32(input logic signed [65:0] v);
    if (v > SAT_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic [31:0] a;
    case (i)
      0: a = 32'h3243F6A8;
      1: a = 32'h1DAC6705;
      2: a = 32'h0FADBAFC;
      3: a = 32'h07F56EA6;
      4: a = 32'h03FEAB76;
      5: a = 32'h01FFD55B;
      6: a = 32'h00FFFAAA;
      7: a = 32'h007FFF55;
      8: a = 32'h003FFFEA;
      9: a = 32'h001FFFFD;
      10: a = 32'h000FFFFF;
      11: a = 32'h0007FFFF;
      12: a = 32'h0003FFFF;
      13: a = 32'h0001FFFF;
      14: a = 32'h0000FFFF;
      15: a = 32'h00007FFF;
      16: a = 32'h00003FFF;
      17: a = 32'h00001FFF;
      18: a = 32'h00000FFF;
      19: a = 32'h000007FF;
      20: a = 32'h000003FF;
      21: a = 32'h000001FF;
      22: a = 32'h000000FF;
      default: a = 32'h0000007F;
    endcase
    return $signed({{(CW-32){1'b0}}, a});
  endfunction

endpackage

// ===== hw/rtl/sqvt_front.sv =====
// Front part: takes request words, scales the corner offsets and runs the CORDIC pipeline.
// Depends on sqvt_pkg; pushes finished words into the queue.
`timescale 1ns / 1ps

module sqvt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  scale_x,
  input  logic signed [31:0]  scale_y,
  input  logic signed [19:0]  angle,
  input  sqvt_pkg::sqvt_cfg_t cfg,
  output logic                push,
  output sqvt_pkg::sqvt_item_t push_data,
  input  logic                full
);
  import sqvt_pkg::*;

  localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  logic en;
  logic v1;
  logic signed [63:0] prod_l, prod_r, prod_t, prod_b;
  q16_t px1, py1;
  logic signed [20:0] ang1;
  logic neg1, rot1;

  logic v_c [0:N];
  sqvt_carry_t carry_c [0:N];
  logic signed [CW-1:0] cx [0:N];
  logic signed [CW-1:0] cy [0:N];
  logic signed [CW-1:0] cz [0:N];
  logic neg_c [0:N];

  logic v_o;
  sqvt_item_t item_o;

  logic signed [20:0] ang_w, ang_a, ang_b;
  logic neg_next;
  logic signed [63:0] rl, rr, rt, rb;

  assign en = !(v_o && full);
  assign in_stall = !en;
  assign push = v_o && !full;
  assign push_data = item_o;

  always_comb begin
    ang_w = 21'(angle);
    if (ang_w > ANG_PI) begin
      ang_a = ang_w - ANG_TWO_PI;
    end else if (ang_w < -ANG_PI) begin
      ang_a = ang_w + ANG_TWO_PI;
    end else begin
      ang_a = ang_w;
    end
    neg_next = 1'b0;
    ang_b = ang_a;
    if (ang_a > ANG_HALF_PI) begin
      ang_b = ang_a - ANG_PI;
      neg_next = 1'b1;
    end else if (ang_a < -ANG_HALF_PI) begin
      ang_b = ang_a + ANG_PI;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      prod_l <= cfg.corner_left * scale_x;
      prod_r <= cfg.corner_right * scale_x;
      prod_t <= cfg.corner_top * scale_y;
      prod_b <= cfg.corner_bottom * scale_y;
      px1 <= pos_x;
      py1 <= pos_y;
      ang1 <= ang_b;
      neg1 <= neg_next;
      rot1 <= (angle != 20'sd0);
    end
  end

  assign rl = (prod_l + 64'sd32768) >>> 16;
  assign rr = (prod_r + 64'sd32768) >>> 16;
  assign rt = (prod_t + 64'sd32768) >>> 16;
  assign rb = (prod_b + 64'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c[0] <= 1'b0;
    end else if (en) begin
      v_c[0] <= v1;
    end
    if (en) begin
      carry_c[0].px <= px1;
      carry_c[0].py <= py1;
      carry_c[0].l <= sat32(66'(rl));
      carry_c[0].r <= sat32(66'(rr));
      carry_c[0].t <= sat32(66'(rt));
      carry_c[0].b <= sat32(66'(rb));
      carry_c[0].rot <= rot1;
      cx[0] <= CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= CW'(ang1) <<< 14;
      neg_c[0] <= neg1;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        v_c[i+1] <= 1'b0;
      end else if (en) begin
        v_c[i+1] <= v_c[i];
      end
      if (en) begin
        carry_c[i+1] <= carry_c[i];
        neg_c[i+1] <= neg_c[i];
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_q30(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v_c[N];
    end
    if (en) begin
      item_o.geo <= carry_c[N];
      item_o.cos_v <= neg_c[N] ? -cx[N] : cx[N];
      item_o.sin_v <= neg_c[N] ? -cy[N] : cy[N];
    end
  end

endmodule

// ===== hw/rtl/sqvt_fifo.sv =====
// Short queue of prepared quad words between the front and back parts.
// Depends on sqvt_pkg for the word type and depth.
`timescale 1ns / 1ps

module sqvt_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sqvt_pkg::sqvt_item_t push_data,
  input  logic                 pop,
  output sqvt_pkg::sqvt_item_t head,
  output logic                 full,
  output logic                 empty
);
  import sqvt_pkg::*;

  sqvt_item_t mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0] count;

  assign full = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/sqvt_back.sv =====
// Back part: expands each queued quad into four vertices, rotates, translates and saturates.
// Depends on sqvt_pkg; reads words from the queue and drives the result channel.
`timescale 1ns / 1ps

module sqvt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  input  sqvt_pkg::sqvt_item_t head,
  output logic                 pop,
  input  sqvt_pkg::sqvt_cfg_t  cfg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   vertex_x,
  output logic signed [31:0]   vertex_y,
  output logic [15:0]          vertex_z,
  output logic [15:0]          tex_u,
  output logic [15:0]          tex_v,
  output logic [31:0]          color,
  output logic [1:0]           corner,
  output logic                 last
);
  import sqvt_pkg::*;

  logic en, issue;
  logic [1:0] k;

  logic va, rota;
  logic [1:0] ka;
  q16_t xa, ya, pxa, pya;
  logic signed [CW-1:0] sa, ca;

  logic vb, rotb;
  logic [1:0] kb;
  q16_t xb, yb, pxb, pyb;
  logic signed [65:0] mxc, mys, mxs, myc;

  logic vc;
  logic [1:0] kc;
  q16_t rx, ry, pxc, pyc;

  logic rt_sel, bt_sel;
  logic signed [65:0] sum_x, sum_y;

  assign en = !(out_valid && out_stall);
  assign issue = en && !empty;
  assign pop = issue && (k == 2'd3);
  assign rt_sel = (k == 2'd1) || (k == 2'd2);
  assign bt_sel = k[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      va <= 1'b0;
    end else if (en) begin
      va <= !empty;
      if (!empty) begin
        k <= k + 2'd1;
      end
    end
    if (en) begin
      ka <= k;
      xa <= rt_sel ? head.geo.r : head.geo.l;
      ya <= bt_sel ? head.geo.b : head.geo.t;
      pxa <= head.geo.px;
      pya <= head.geo.py;
      rota <= head.geo.rot;
      sa <= head.sin_v;
      ca <= head.cos_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      kb <= ka;
      xb <= xa;
      yb <= ya;
      pxb <= pxa;
      pyb <= pya;
      rotb <= rota;
      mxc <= xa * ca;
      mys <= ya * sa;
      mxs <= xa * sa;
      myc <= ya * ca;
    end
  end

  assign sum_x = (mxc - mys + 66'sd536870912) >>> 30;
  assign sum_y = (mxs + myc + 66'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      kc <= kb;
      pxc <= pxb;
      pyc <= pyb;
      rx <= rotb ? sat32(sum_x) : xb;
      ry <= rotb ? sat32(sum_y) : yb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vc;
    end
    if (en) begin
      vertex_x <= sat32(66'(rx) + 66'(pxc));
      vertex_y <= sat32(66'(ry) + 66'(pyc));
      vertex_z <= cfg.depth;
      tex_u <= ((kc == 2'd1) || (kc == 2'd2)) ? cfg.uv_corners[47:32] : cfg.uv_corners[15:0];
      tex_v <= kc[1] ? cfg.uv_corners[63:48] : cfg.uv_corners[31:16];
      case (kc)
        2'd0: color <= cfg.colors_first_pair[31:0];
        2'd1: color <= cfg.colors_first_pair[63:32];
        2'd2: color <= cfg.colors_second_pair[31:0];
        default: color <= cfg.colors_second_pair[63:32];
      endcase
      corner <= kc;
      last <= (kc == 2'd3);
    end
  end

endmodule

// ===== hw/rtl/sprite_quad_vertex_transform_unit.sv =====
// Top level of the sprite quad vertex transform: configuration registers and the three parts.
// Depends on sqvt_pkg, sqvt_front, sqvt_fifo and sqvt_back.
//
//   Channel  Handshake             Word
//   in       in_valid / in_stall   pos_x, pos_y, scale_x, scale_y, angle
//   out      out_valid / out_stall vertex_x, vertex_y, vertex_z, tex_u, tex_v, color, corner, last
//   cfg      cfg_write             cfg_index, cfg_data
//
// The back part emits one vertex per cycle while the queue is non-empty and the output is not stalled,
// and it pops each quad word from the queue when it issues that quad's fourth vertex.
// The front pipeline can take a word every cycle until the four-entry queue fills.
// A stall on the output holds the back part; the queue then fills and raises in_stall.
// Reset is synchronous; it clears all control state and sets the configuration registers to their reset values.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [19:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [15:0]        vertex_z,
  output logic [15:0]        tex_u,
  output logic [15:0]        tex_v,
  output logic [31:0]        color,
  output logic [1:0]         corner,
  output logic               last
);
  import sqvt_pkg::*;

  sqvt_cfg_t cfg;
  logic push, pop, full, empty;
  sqvt_item_t push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.corner_left <= '0;
      cfg.corner_top <= '0;
      cfg.corner_right <= '0;
      cfg.corner_bottom <= '0;
      cfg.uv_corners <= 64'h8000800000000000;
      cfg.depth <= 16'h8000;
      cfg.colors_first_pair <= '1;
      cfg.colors_second_pair <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CORNER_LEFT:   cfg.corner_left <= cfg_data[31:0];
        REG_CORNER_TOP:    cfg.corner_top <= cfg_data[31:0];
        REG_CORNER_RIGHT:  cfg.corner_right <= cfg_data[31:0];
        REG_CORNER_BOTTOM: cfg.corner_bottom <= cfg_data[31:0];
        REG_UV_CORNERS:    cfg.uv_corners <= cfg_data;
        REG_DEPTH:         cfg.depth <= cfg_data[15:0];
        REG_COLORS_FIRST:  cfg.colors_first_pair <= cfg_data;
        REG_COLORS_SECOND: cfg.colors_second_pair <= cfg_data;
        default: ;
      endcase
    end
  end

  sqvt_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pos_x(pos_x), .pos_y(pos_y), .scale_x(scale_x), .scale_y(scale_y), .angle(angle),
    .cfg(cfg), .push(push), .push_data(push_data), .full(full)
  );

  sqvt_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(push), .push_data(push_data), .pop(pop), .head(head),
    .full(full), .empty(empty)
  );

  sqvt_back u_back (
    .clk(clk), .rst(rst),
    .empty(empty), .head(head), .pop(pop), .cfg(cfg),
    .out_valid(out_valid), .out_stall(out_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
    .tex_u(tex_u), .tex_v(tex_v), .color(color), .corner(corner), .last(last)
  );

endmodule

// ===== bench/sprite_quad_vertex_transform_unit_tb.sv =====
// Self-checking testbench for the sprite quad vertex transform unit.
// It predicts each quad's four vertices, checks them in order under random idling and stalls,
// and depends on sqvt_pkg and the RTL.
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_unit_tb;
  import sqvt_pkg::*;

  localparam logic [3:0] REG_UNMAPPED = 4'd11;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 16;
  localparam longint ROT_PI = 205887;
  localparam longint ROT_TWO_PI = 411775;
  localparam longint ROT_HALF_PI = 102944;
  localparam longint ROT_GAIN = 64'h26DD3B6A;
  localparam longint ARCTAN_Q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [19:0] angle;
  } quad_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        z;
    logic [15:0]        u;
    logic [15:0]        v;
    logic [31:0]        color;
    logic [1:0]         corner;
    logic               last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, scale_x = '0, scale_y = '0;
  logic signed [19:0] angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] vertex_x, vertex_y;
  logic [15:0] vertex_z, tex_u, tex_v;
  logic [31:0] color;
  logic [1:0] corner;
  logic last;

  sqvt_cfg_t shadow_cfg;
  quad_req_t pending_quads[$];
  quad_req_t quad_on_bus;
  vertex_t expected_vertices[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quads_accepted = 0;
  int vertices_checked = 0;
  int quiet_cycles = 0;

  sprite_quad_vertex_transform_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_offset(logic signed [31:0] off, logic signed [31:0] sc);
    longint p;
    p = longint'(off) * longint'(sc) + 64'sd32768;
    return clamp32(p >>> 16);
  endfunction

  task automatic cordic_sin_cos(longint ang, output longint s, output longint c);
    bit flip;
    longint x, y, z, dx, dy;
    int steps;
    flip = 1'b0;
    x = ROT_GAIN;
    y = 0;
    while (ang > ROT_PI) ang -= ROT_TWO_PI;
    while (ang < -ROT_PI) ang += ROT_TWO_PI;
    if (ang > ROT_HALF_PI) begin
      ang -= ROT_PI;
      flip = 1'b1;
    end else if (ang < -ROT_HALF_PI) begin
      ang += ROT_PI;
      flip = 1'b1;
    end
    z = ang * 16384;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic predict_quad(quad_req_t q);
    longint l, r, t, b, s, c, x, y, tx, ty;
    bit rot;
    vertex_t vx;
    l = scale_offset(shadow_cfg.corner_left, q.scale_x);
    r = scale_offset(shadow_cfg.corner_right, q.scale_x);
    t = scale_offset(shadow_cfg.corner_top, q.scale_y);
    b = scale_offset(shadow_cfg.corner_bottom, q.scale_y);
    rot = (q.angle != 0);
    s = 0;
    c = 0;
    if (rot) cordic_sin_cos(longint'(q.angle), s, c);
    for (int k = 0; k < 4; k++) begin
      x = (k == 1 || k == 2) ? r : l;
      y = (k >= 2) ? b : t;
      if (rot) begin
        tx = clamp32((x * c - y * s + (64'sd1 <<< 29)) >>> 30);
        ty = clamp32((x * s + y * c + (64'sd1 <<< 29)) >>> 30);
        x = tx;
        y = ty;
      end
      vx.x = clamp32(x + longint'(q.pos_x));
      vx.y = clamp32(y + longint'(q.pos_y));
      vx.z = shadow_cfg.depth;
      vx.u = (k == 1 || k == 2) ? shadow_cfg.uv_corners[47:32] : shadow_cfg.uv_corners[15:0];
      vx.v = (k >= 2) ? shadow_cfg.uv_corners[63:48] : shadow_cfg.uv_corners[31:16];
      case (k)
        0: vx.color = shadow_cfg.colors_first_pair[31:0];
        1: vx.color = shadow_cfg.colors_first_pair[63:32];
        2: vx.color = shadow_cfg.colors_second_pair[31:0];
        default: vx.color = shadow_cfg.colors_second_pair[63:32];
      endcase
      vx.corner = 2'(k);
      vx.last = (k == 3);
      expected_vertices.push_back(vx);
    end
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver: a new word is offered only once the previous one was taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_quad(quad_on_bus);
        quads_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_quads.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          quad_on_bus = pending_quads.pop_front();
          pos_x <= quad_on_bus.pos_x;
          pos_y <= quad_on_bus.pos_y;
          scale_x <= quad_on_bus.scale_x;
          scale_y <= quad_on_bus.scale_y;
          angle <= quad_on_bus.angle;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          $error("vertex word with no quad outstanding");
          errors++;
        end else begin
          e = expected_vertices.pop_front();
          check_field("vertex_x", e.x, vertex_x);
          check_field("vertex_y", e.y, vertex_y);
          check_field("vertex_z", e.z, vertex_z);
          check_field("tex_u", e.u, tex_u);
          check_field("tex_v", e.v, tex_v);
          check_field("color", e.color, color);
          check_field("corner", e.corner, corner);
          check_field("last", e.last, last);
          vertices_checked++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic write_reg(logic [3:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_CORNER_LEFT:   shadow_cfg.corner_left = data[31:0];
      REG_CORNER_TOP:    shadow_cfg.corner_top = data[31:0];
      REG_CORNER_RIGHT:  shadow_cfg.corner_right = data[31:0];
      REG_CORNER_BOTTOM: shadow_cfg.corner_bottom = data[31:0];
      REG_UV_CORNERS:    shadow_cfg.uv_corners = data;
      REG_DEPTH:         shadow_cfg.depth = data[15:0];
      REG_COLORS_FIRST:  shadow_cfg.colors_first_pair = data;
      REG_COLORS_SECOND: shadow_cfg.colors_second_pair = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [31:0] l, logic [31:0] t, logic [31:0] r, logic [31:0] b);
    write_reg(REG_CORNER_LEFT, {$urandom, l});
    write_reg(REG_CORNER_TOP, {$urandom, t});
    write_reg(REG_CORNER_RIGHT, {$urandom, r});
    write_reg(REG_CORNER_BOTTOM, {$urandom, b});
    write_reg(REG_UV_CORNERS, {$urandom, $urandom});
    write_reg(REG_DEPTH, {$urandom, $urandom});
    write_reg(REG_COLORS_FIRST, {$urandom, $urandom});
    write_reg(REG_COLORS_SECOND, {$urandom, $urandom});
    write_reg(REG_UNMAPPED, {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    while (pending_quads.size() != 0 || in_valid || expected_vertices.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic quad_req_t random_quad();
    quad_req_t q;
    int pick;
    pick = $urandom_range(0, 9);
    q.pos_x = $urandom;
    q.pos_y = $urandom;
    q.angle = 20'($urandom);
    if (pick < 6) begin
      q.pos_x = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
      q.pos_y = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
      q.scale_x = $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
      q.scale_y = $signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000;
    end else begin
      q.scale_x = $urandom;
      q.scale_y = $urandom;
    end
    if (pick == 8) q.angle = '0;
    if (pick == 9) q.angle = 20'(ROT_HALF_PI * $urandom_range(0, 8) - 4 * ROT_HALF_PI
                                + $urandom_range(0, 4) - 2);
    return q;
  endfunction

  task automatic queue_quad(logic [31:0] px, logic [31:0] py, logic [31:0] sx,
                            logic [31:0] sy, logic [19:0] ang);
    quad_req_t q;
    q.pos_x = px;
    q.pos_y = py;
    q.scale_x = sx;
    q.scale_y = sy;
    q.angle = ang;
    pending_quads.push_back(q);
  endtask

  initial begin
    shadow_cfg.corner_left = '0;
    shadow_cfg.corner_top = '0;
    shadow_cfg.corner_right = '0;
    shadow_cfg.corner_bottom = '0;
    shadow_cfg.uv_corners = 64'h8000800000000000;
    shadow_cfg.depth = 16'h8000;
    shadow_cfg.colors_first_pair = '1;
    shadow_cfg.colors_second_pair = '1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values, then a typical sprite with directed corner cases.
    queue_quad(32'h00010000, 32'hFFFF0000, 32'h00010000, 32'h00010000, 20'd0);
    wait_drained();
    configure(32'hFFF00000, 32'h00100000, 32'h00100000, 32'hFFF00000);
    queue_quad(32'h00050000, 32'h00030000, 32'h00010000, 32'h00010000, 20'd0);
    queue_quad(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 20'd0);
    queue_quad(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 20'd0);
    queue_quad(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'h00010000, 20'h7FFFF);
    queue_quad(32'h80000000, 32'h7FFFFFFF, 32'h00010000, 32'h00010000, 20'h80000);
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'(ROT_PI));
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'(-ROT_PI));
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'(ROT_HALF_PI));
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'(ROT_HALF_PI + 1));
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'(-ROT_HALF_PI - 1));
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'(ROT_PI + 1));
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'd1);
    queue_quad(0, 0, 32'h00010000, 32'h00010000, 20'hFFFFF);
    queue_quad(32'h12345678, 32'hEDCBA987, 32'hFFFF0000, 32'h00020000, 20'h0C000);
    queue_quad(32'h7FFF0000, 32'h80010000, 32'h00100000, 32'hFFF00000, 20'h19220);
    queue_quad(32'hFFFFFFFF, 32'h00000001, 32'h00000000, 32'h00000000, 20'h3243F);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure($urandom, $urandom, $urandom, $urandom);
        1: configure(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        2: configure(32'hFFF80000, 32'h00040000, 32'h00080000, 32'hFFFC0000);
        3: configure(32'h00000000, 32'hFFFFFFFF, 32'h00000001, 32'h00000000);
        default: configure($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000,
                           $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000,
                           $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000,
                           $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
      endcase
      case (phase)
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (87) pending_quads.push_back(random_quad());
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    if (expected_vertices.size() != 0) begin
      $error("%0d vertex words never arrived", expected_vertices.size());
      errors++;
    end
    $display("Checked %0d vertex words from %0d quads over seven register settings,",
             vertices_checked, quads_accepted);
    $display("with zero and wrapped angles, saturation and random idling on both sides.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
